[sv/rgb_median_filter_defines.svh]
// ----------------------------------------------------------------------------
// rgb_median_filter_defines.svh
// Assertion macros shared by the median filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_MEDIAN_FILTER_DEFINES_SVH
`define RGB_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// Types and fixed constants of the RGB median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

    // Configuration register widths and related constants
    localparam int IMG_W_BITS  = 11;
    localparam int IMG_H_BITS  = 13;
    localparam int WIN_BITS    = 5;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int MIN_WINDOW  = 3;
    localparam int BIN_W       = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_GATHER,
        ST_DRAIN,
        ST_PICK,
        ST_FINISH
    } t_state;

    // Control toward the histogram unit
    typedef struct packed {
        logic        sample;
        logic [23:0] pixel;
        logic        pick;
    } t_hist_cmd;

    // Status from the histogram unit
    typedef struct packed {
        logic       idle;
        logic       done;
        logic [7:0] med_r;
        logic [7:0] med_g;
        logic [7:0] med_b;
    } t_hist_stat;

endpackage

`default_nettype wire

[sv/rmf_stream_if.sv]
// ----------------------------------------------------------------------------
// rmf_stream_if
// Valid/ready stream channel; one transaction per edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmf_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/rmf_ram.sv]
// ----------------------------------------------------------------------------
// rmf_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/rmf_hist.sv]
// ----------------------------------------------------------------------------
// rmf_hist
// Per-channel histogram RAMs: counts window samples, then scans the bins
// for the median while clearing them for the next window.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_hist #(
    parameter int CNT_W = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rmf_pkg::t_hist_cmd i_cmd,
    input  wire logic [CNT_W-1:0]   i_k,
    output rmf_pkg::t_hist_stat     o_stat
);

    localparam int BW   = rmf_pkg::BIN_W;
    localparam int BINS = 1 << BW;

    logic             r_clr_busy;
    logic [BW-1:0]    r_clr_addr;
    logic             r_b_v;
    logic [BW-1:0]    r_b_byte [3];
    logic             r_c_v;
    logic [BW-1:0]    r_c_addr [3];
    logic [CNT_W-1:0] r_c_data [3];
    logic             r_pick_act;
    logic [BW-1:0]    r_pv;
    logic             r_pp_v;
    logic [BW-1:0]    r_pp_addr;
    logic [CNT_W-1:0] r_acc    [3];
    logic             r_found  [3];
    logic [BW-1:0]    r_med    [3];
    logic [CNT_W-1:0] r_k;
    logic             r_done;

    logic [BW-1:0]    w_byte   [3];
    logic [CNT_W-1:0] w_rdata  [3];
    logic [CNT_W-1:0] w_inc    [3];
    logic [CNT_W-1:0] w_acc    [3];

    // One RAM per channel, shared write control
    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [CNT_W-1:0] w_cnt;
        logic [BW-1:0]    w_raddr;
        logic [BW-1:0]    w_waddr;
        logic [CNT_W-1:0] w_wdata;

        assign w_byte[c] = i_cmd.pixel[23-8*c -: 8];

        // Forward the count written last cycle to the same bin
        assign w_cnt  = (r_c_v && r_c_addr[c] == r_b_byte[c]) ? r_c_data[c] : w_rdata[c];
        assign w_inc[c] = w_cnt + CNT_W'(1);
        assign w_acc[c] = r_acc[c] + w_rdata[c];

        assign w_raddr = r_pick_act ? r_pv : w_byte[c];
        assign w_waddr = r_clr_busy ? r_clr_addr : (r_b_v ? r_b_byte[c] : r_pp_addr);
        assign w_wdata = (!r_clr_busy && r_b_v) ? w_inc[c] : '0;

        rmf_ram #(
            .WIDTH (CNT_W),
            .DEPTH (BINS)
        ) u_bins (
            .i_clk   (i_clk),
            .i_we    (r_clr_busy || r_b_v || r_pp_v),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[c])
        );
    end

    // Control: clearing pass, sample pipeline, bin scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b_v      <= 1'b0;
            r_c_v      <= 1'b0;
            r_pick_act <= 1'b0;
            r_pv       <= '0;
            r_pp_v     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + BW'(1);
                if (r_clr_addr == BW'(BINS-1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_b_v <= i_cmd.sample;
            r_c_v <= r_b_v;
            if (i_cmd.pick) begin
                r_pick_act <= 1'b1;
                r_pv       <= '0;
            end else if (r_pick_act) begin
                r_pv <= r_pv + BW'(1);
                if (r_pv == BW'(BINS-1)) begin
                    r_pick_act <= 1'b0;
                end
            end
            r_pp_v <= r_pick_act;
            r_done <= r_pp_v && (r_pp_addr == BW'(BINS-1));
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_pp_addr <= r_pv;
        if (i_cmd.pick) begin
            r_k <= i_k;
        end
        for (int c = 0; c < 3; c++) begin
            r_b_byte[c] <= w_byte[c];
            r_c_addr[c] <= r_b_byte[c];
            r_c_data[c] <= w_inc[c];
            if (i_cmd.pick) begin
                r_acc[c]   <= '0;
                r_found[c] <= 1'b0;
                r_med[c]   <= '1;
            end else if (r_pp_v) begin
                r_acc[c] <= w_acc[c];
                if (!r_found[c] && w_acc[c] > r_k) begin
                    r_found[c] <= 1'b1;
                    r_med[c]   <= r_pp_addr;
                end
            end
        end
    end

    assign o_stat.idle  = !r_clr_busy && !r_b_v && !r_pick_act && !r_pp_v;
    assign o_stat.done  = r_done;
    assign o_stat.med_r = r_med[0];
    assign o_stat.med_g = r_med[1];
    assign o_stat.med_b = r_med[2];

endmodule

`default_nettype wire

[sv/rgb_median_filter.sv]
// ----------------------------------------------------------------------------
// rgb_median_filter
// Streaming per-channel 2-D median filter on RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes pixel transactions in raster order (kind 0) and flush ticks
//   (kind 1); o_res gives one median result per image pixel, in raster order,
//   with frame_end set on the frame's last one. Flush ticks drain the last
//   rows. The config port (width, height, window size) is to be written only
//   while idle; the block does not enforce this. A write restarts the frame.
//   Each accepted transaction with no result goes back to idle after the check
//   state. When it yields one, the window's n pixels (n <= (2*half+1)^2,
//   361 at size 19) are read from the line store RAM one per cycle and
//   counted in three bin RAMs, then the 256 bins are scanned one per cycle;
//   the result time is set by the line store read port and the bin scan.
//   After reset the bin RAMs are cleared in one pass over the 256 bins; i_pix
//   is not ready meanwhile. A result waits in the output register while o_res
//   is stalled; the next transaction is still taken, and its result waits
//   until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_median_filter_defines.svh"

module rgb_median_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_SIZE   = 19
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rmf_stream_if.sink                          i_pix,
    rmf_stream_if.source                        o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [rmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CB     = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SR     = 2 * (MAX_SIZE / 2) + 2;
    localparam int SR_W   = $clog2(SR);
    localparam int HALF_W = $clog2(MAX_SIZE / 2 + 1);
    localparam int CNT_W  = $clog2((2 * (MAX_SIZE / 2) + 1) * (2 * (MAX_SIZE / 2) + 1) + 1);
    localparam int LS_DEPTH = SR * (1 << CB);
    localparam int LS_AW  = $clog2(LS_DEPTH);

    // Effective register values
    function automatic logic [COL_W-1:0] sat_w(input logic [rmf_pkg::IMG_W_BITS-1:0] v);
        int t;
        t = int'(v);
        if (t < 1) t = 1;
        if (t > MAX_WIDTH) t = MAX_WIDTH;
        return COL_W'(t);
    endfunction

    function automatic logic [ROW_W-1:0] sat_h(input logic [rmf_pkg::IMG_H_BITS-1:0] v);
        int t;
        t = int'(v);
        if (t < 1) t = 1;
        if (t > MAX_HEIGHT) t = MAX_HEIGHT;
        return ROW_W'(t);
    endfunction

    function automatic logic [HALF_W-1:0] sat_half(input logic [rmf_pkg::WIN_BITS-1:0] v);
        int t;
        t = int'(v);
        if (t < rmf_pkg::MIN_WINDOW) t = rmf_pkg::MIN_WINDOW;
        if (t > MAX_SIZE) t = MAX_SIZE;
        return HALF_W'(t >> 1);
    endfunction

    rmf_pkg::t_state r_state, n_state;

    logic [COL_W-1:0]  r_w;
    logic [ROW_W-1:0]  r_h;
    logic [HALF_W-1:0] r_half;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [SR_W-1:0]   r_in_srow, r_out_srow;
    logic [ROW_W-1:0]  r_grow, r_yhi;
    logic [COL_W-1:0]  r_gx, r_xlo, r_xhi;
    logic [SR_W-1:0]   r_gsrow;
    logic [CNT_W-1:0]  r_n;
    logic              r_a_v;
    logic              r_ov;
    rmf_pkg::t_out_item r_opay;

    rmf_pkg::t_hist_cmd  w_cmd;
    rmf_pkg::t_hist_stat w_stat;
    logic [23:0]         w_ls_rdata;
    logic [LS_AW-1:0]    w_ls_raddr, w_ls_waddr;
    logic                w_ls_we;
    logic                w_fire_in, w_fire_out;
    logic                w_ready_res, w_last_issue, w_start_pick, w_load;

    assign w_fire_in  = i_pix.valid && i_pix.ready;
    assign w_fire_out = o_res.valid && o_res.ready;

    // Window of the next output pixel complete?
    logic [ROW_W:0] w_rr, w_rr_s;
    logic [COL_W:0] w_cc, w_cc_s;
    always_comb begin
        w_rr_s = {1'b0, r_out_row} + (ROW_W+1)'(r_half);
        w_cc_s = {1'b0, r_out_col} + (COL_W+1)'(r_half);
        w_rr   = (w_rr_s > {1'b0, r_h - ROW_W'(1)}) ? {1'b0, r_h - ROW_W'(1)} : w_rr_s;
        w_cc   = (w_cc_s > {1'b0, r_w - COL_W'(1)}) ? {1'b0, r_w - COL_W'(1)} : w_cc_s;
        w_ready_res = (r_in_row >= r_h) || ({1'b0, r_in_row} > w_rr) ||
                      ({1'b0, r_in_row} == w_rr && {1'b0, r_in_col} > w_cc);
    end

    // Clipped window bounds
    logic [ROW_W-1:0] w_dy, w_ylo, w_yhi;
    logic [COL_W-1:0] w_dx, w_xlo, w_xhi;
    logic [SR_W:0]    w_gsrow;
    always_comb begin
        w_dy  = (r_out_row >= ROW_W'(r_half)) ? ROW_W'(r_half) : r_out_row;
        w_dx  = (r_out_col >= COL_W'(r_half)) ? COL_W'(r_half) : r_out_col;
        w_ylo = r_out_row - w_dy;
        w_xlo = r_out_col - w_dx;
        w_yhi = w_rr[ROW_W-1:0];
        w_xhi = w_cc[COL_W-1:0];
        if ({1'b0, r_out_srow} >= (SR_W+1)'(w_dy)) begin
            w_gsrow = {1'b0, r_out_srow} - (SR_W+1)'(w_dy);
        end else begin
            w_gsrow = {1'b0, r_out_srow} + (SR_W+1)'(SR) - (SR_W+1)'(w_dy);
        end
    end

    assign w_last_issue = (r_grow == r_yhi) && (r_gx == r_xhi);
    assign w_start_pick = (r_state == rmf_pkg::ST_DRAIN) && !r_a_v && w_stat.idle;
    assign w_load       = (r_state == rmf_pkg::ST_FINISH) && (!r_ov || o_res.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmf_pkg::ST_CLEAR:  if (w_stat.idle) n_state = rmf_pkg::ST_IDLE;
            rmf_pkg::ST_IDLE:   if (w_fire_in) n_state = rmf_pkg::ST_CHECK;
            rmf_pkg::ST_CHECK:  n_state = w_ready_res ? rmf_pkg::ST_SETUP : rmf_pkg::ST_IDLE;
            rmf_pkg::ST_SETUP:  n_state = rmf_pkg::ST_GATHER;
            rmf_pkg::ST_GATHER: if (w_last_issue) n_state = rmf_pkg::ST_DRAIN;
            rmf_pkg::ST_DRAIN:  if (w_start_pick) n_state = rmf_pkg::ST_PICK;
            rmf_pkg::ST_PICK:   if (w_stat.done) n_state = rmf_pkg::ST_FINISH;
            rmf_pkg::ST_FINISH: if (w_load) n_state = rmf_pkg::ST_IDLE;
            default:            n_state = rmf_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        i_pix.ready  = (r_state == rmf_pkg::ST_IDLE);
        w_cmd.sample = r_a_v;
        w_cmd.pixel  = w_ls_rdata;
        w_cmd.pick   = w_start_pick;
        w_ls_we      = w_fire_in && !i_pix.payload.kind && (r_in_row < r_h);
        w_ls_waddr   = LS_AW'({r_in_srow, r_in_col[CB-1:0]});
        w_ls_raddr   = LS_AW'({r_gsrow, r_gx[CB-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Config, positions, gather read valid, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= COL_W'(1);
            r_h        <= ROW_W'(1);
            r_half     <= HALF_W'(1);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_srow  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_srow <= '0;
            r_a_v      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_a_v <= (r_state == rmf_pkg::ST_GATHER);
            if (w_fire_out) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx inside {rmf_pkg::CFG_IMAGE_WIDTH,
                                               rmf_pkg::CFG_IMAGE_HEIGHT,
                                               rmf_pkg::CFG_WINDOW_SIZE})) begin
                case (i_cfg_idx)
                    rmf_pkg::CFG_IMAGE_WIDTH:
                        r_w <= sat_w(i_cfg_data[rmf_pkg::IMG_W_BITS-1:0]);
                    rmf_pkg::CFG_IMAGE_HEIGHT:
                        r_h <= sat_h(i_cfg_data[rmf_pkg::IMG_H_BITS-1:0]);
                    default:
                        r_half <= sat_half(i_cfg_data[rmf_pkg::WIN_BITS-1:0]);
                endcase
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_srow  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_srow <= '0;
            end else begin
                // Input position advance on a stored pixel
                if (w_ls_we) begin
                    if (r_in_col + COL_W'(1) >= r_w) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + ROW_W'(1);
                        r_in_srow <= (r_in_srow == SR_W'(SR-1)) ? '0 : r_in_srow + SR_W'(1);
                    end else begin
                        r_in_col <= r_in_col + COL_W'(1);
                    end
                end
                // Result delivery and output position advance
                if (w_load) begin
                    r_ov <= 1'b1;
                    if (r_out_col + COL_W'(1) >= r_w) begin
                        if (r_out_row + ROW_W'(1) >= r_h) begin
                            r_in_row   <= '0;
                            r_in_col   <= '0;
                            r_in_srow  <= '0;
                            r_out_row  <= '0;
                            r_out_col  <= '0;
                            r_out_srow <= '0;
                        end else begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + ROW_W'(1);
                            r_out_srow <= (r_out_srow == SR_W'(SR-1)) ? '0 :
                                          r_out_srow + SR_W'(1);
                        end
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // Window scan counters and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == rmf_pkg::ST_SETUP) begin
            r_grow  <= w_ylo;
            r_yhi   <= w_yhi;
            r_gx    <= w_xlo;
            r_xlo   <= w_xlo;
            r_xhi   <= w_xhi;
            r_gsrow <= w_gsrow[SR_W-1:0];
            r_n     <= '0;
        end else if (r_state == rmf_pkg::ST_GATHER) begin
            r_n <= r_n + CNT_W'(1);
            if (r_gx == r_xhi) begin
                r_gx    <= r_xlo;
                r_grow  <= r_grow + ROW_W'(1);
                r_gsrow <= (r_gsrow == SR_W'(SR-1)) ? '0 : r_gsrow + SR_W'(1);
            end else begin
                r_gx <= r_gx + COL_W'(1);
            end
        end
        if (w_load) begin
            r_opay.red_out   <= w_stat.med_r;
            r_opay.green_out <= w_stat.med_g;
            r_opay.blue_out  <= w_stat.med_b;
            r_opay.frame_end <= (r_out_col + COL_W'(1) >= r_w) &&
                                (r_out_row + ROW_W'(1) >= r_h);
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.payload = r_opay;

    rmf_ram #(
        .WIDTH (24),
        .DEPTH (LS_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ls_we),
        .i_waddr (w_ls_waddr),
        .i_wdata ({i_pix.payload.red_in, i_pix.payload.green_in, i_pix.payload.blue_in}),
        .i_raddr (w_ls_raddr),
        .o_rdata (w_ls_rdata)
    );

    rmf_hist #(
        .CNT_W (CNT_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_k     (r_n >> 1),
        .o_stat  (w_stat)
    );

    // Checks
    `RMF_ASSERT_NOW(a_scan_in_window, r_state == rmf_pkg::ST_GATHER, r_gx >= r_xlo && r_gx <= r_xhi && r_grow <= r_yhi, "window scan left its bounds")
    `RMF_ASSERT_NOW(a_done_in_pick, w_stat.done, r_state == rmf_pkg::ST_PICK, "median done outside pick phase")
    `RMF_ASSERT_NEXT(a_pick_after_drain, w_start_pick, !r_a_v && !w_cmd.sample, "line store read still in flight during bin scan")

endmodule

`default_nettype wire

[test/rgb_median_filter_tb.sv]
// ----------------------------------------------------------------------------
// rgb_median_filter_tb
// Drives pixel and flush transactions into the RGB median filter, predicts
// each clipped-window per-channel median, and compares the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_median_filter_tb;

    localparam int MAXW = 1024;
    localparam int MAXH = 4096;
    localparam int MAXS = 19;
    localparam int ROWS = 2 * (MAXS / 2) + 2;
    localparam int WATCHDOG = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rmf_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rmf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rmf_stream_if #(.t_payload(rmf_pkg::t_in_item))  pix_if ();
    rmf_stream_if #(.t_payload(rmf_pkg::t_out_item)) res_if ();

    rgb_median_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state
    logic [23:0] pixel_store [ROWS*MAXW];
    int unsigned img_w_reg, img_h_reg, win_reg;
    int unsigned in_r, in_c, out_r, out_c;
    rmf_pkg::t_out_item median_q [$];

    int errors = 0;
    int idle_cnt = 0;
    bit sink_hold = 0;      // long receiver hold-off
    bit sink_no_idle = 0;
    bit src_no_idle = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned slot(int unsigned r, int unsigned c);
        return (r % ROWS) * MAXW + (c % MAXW);
    endfunction

    function automatic void frame_restart();
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    endfunction

    // Upper median of each channel over the clipped window
    function automatic void predict_median(input rmf_pkg::t_in_item it);
        int unsigned w, h, hw, rr, cc, ylo, yhi, xlo, xhi, n, k, acc;
        int hist [3][256];
        rmf_pkg::t_out_item res;
        bit ready;
        w = clampu(img_w_reg, 1, MAXW);
        h = clampu(img_h_reg, 1, MAXH);
        hw = clampu(win_reg, 3, MAXS) / 2;
        if (it.kind == 1'b0 && in_r < h) begin
            pixel_store[slot(in_r, in_c)] = {it.red_in, it.green_in, it.blue_in};
            in_c++;
            if (in_c >= w) begin
                in_c = 0;
                in_r++;
            end
        end
        rr = (out_r + hw > h - 1) ? h - 1 : out_r + hw;
        cc = (out_c + hw > w - 1) ? w - 1 : out_c + hw;
        ready = (in_r >= h) || (in_r > rr) || (in_r == rr && in_c > cc);
        if (!ready) return;
        ylo = out_r >= hw ? out_r - hw : 0;
        xlo = out_c >= hw ? out_c - hw : 0;
        yhi = rr;
        xhi = cc;
        foreach (hist[i, j]) hist[i][j] = 0;
        n = 0;
        for (int unsigned y = ylo; y <= yhi; y++) begin
            for (int unsigned x = xlo; x <= xhi; x++) begin
                logic [23:0] p;
                p = pixel_store[slot(y, x)];
                hist[0][p[23:16]]++;
                hist[1][p[15:8]]++;
                hist[2][p[7:0]]++;
                n++;
            end
        end
        k = n / 2;
        for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] m;
            acc = 0;
            m = 8'd255;
            for (int v = 0; v < 256; v++) begin
                acc += hist[ch][v];
                if (acc > k) begin
                    m = v[7:0];
                    break;
                end
            end
            if (ch == 0) res.red_out = m;
            else if (ch == 1) res.green_out = m;
            else res.blue_out = m;
        end
        res.frame_end = 1'b0;
        out_c++;
        if (out_c >= w) begin
            out_c = 0;
            out_r++;
        end
        if (out_r >= h) begin
            res.frame_end = 1'b1;
            frame_restart();
        end
        median_q.push_back(res);
    endfunction

    // Send one transaction, predict at acceptance
    task automatic send_item(input rmf_pkg::t_in_item it);
        if (!src_no_idle) begin
            while ($urandom_range(99) < 13) @(negedge i_clk);
        end
        pix_if.valid = 1'b1;
        pix_if.payload = it;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_median(it);
        @(negedge i_clk);
        pix_if.valid = 1'b0;
    endtask

    function automatic rmf_pkg::t_in_item rand_pixel();
        rmf_pkg::t_in_item it;
        it.kind = 1'b0;
        it.red_in = $urandom_range(255);
        it.green_in = $urandom_range(255);
        it.blue_in = $urandom_range(255);
        return it;
    endfunction

    task automatic send_pixel(input logic [7:0] r, g, b);
        rmf_pkg::t_in_item it;
        it = '{kind: 1'b0, red_in: r, green_in: g, blue_in: b};
        send_item(it);
    endtask

    task automatic send_flush();
        rmf_pkg::t_in_item it;
        it = rand_pixel();
        it.kind = 1'b1;
        send_item(it);
    endtask

    // Wait until all results are out, then let the block settle
    task automatic drain_wait();
        while (median_q.size() != 0) @(negedge i_clk);
        repeat (800) @(negedge i_clk);
    endtask

    task automatic write_reg(input rmf_pkg::t_cfg_idx idx, input int unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[rmf_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            rmf_pkg::CFG_IMAGE_WIDTH: begin
                img_w_reg = val & 32'h7FF;
                frame_restart();
            end
            rmf_pkg::CFG_IMAGE_HEIGHT: begin
                img_h_reg = val & 32'h1FFF;
                frame_restart();
            end
            rmf_pkg::CFG_WINDOW_SIZE: begin
                win_reg = val & 32'h1F;
                frame_restart();
            end
            default: ;
        endcase
    endtask

    task automatic set_frame(input int unsigned w, h, s);
        drain_wait();
        write_reg(rmf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(rmf_pkg::CFG_WINDOW_SIZE, s);
    endtask

    // One whole frame of random pixels, then flushes until its last result
    task automatic run_frame(input int unsigned w, h);
        int unsigned ew, eh;
        ew = clampu(w & 32'h7FF, 1, MAXW);
        eh = clampu(h & 32'h1FFF, 1, MAXH);
        for (int i = 0; i < ew * eh; i++) send_item(rand_pixel());
        while (in_r != 0 || out_r != 0 || out_c != 0) send_flush();
    endtask

    // Directed: extreme values, flush before ready, pixel beyond the frame end
    task automatic test_directed();
        set_frame(3, 3, 3);
        send_flush();
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_flush();
        send_pixel(8'h55, 8'hAA, 8'h01);
        send_pixel(8'hAA, 8'h55, 8'h80);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h7F, 8'h80, 8'hFE);
        send_pixel(8'h01, 8'hFE, 8'h7F);
        send_pixel(8'h80, 8'h7F, 8'h10);
        // extra pixels act as flushes
        repeat (4) send_item(rand_pixel());
        while (out_r != 0 || out_c != 0 || in_r != 0) send_flush();
    endtask

    // Extreme and out-of-range register settings, bad index ignored
    task automatic test_config_extremes();
        set_frame(1, 1, 3);
        run_frame(1, 1);
        set_frame(0, 0, 0);
        run_frame(0, 0);
        set_frame(1, 24, 31);
        run_frame(1, 24);
        set_frame(2047, 1, 4);
        run_frame(2047, 1);
        drain_wait();
        write_reg(rmf_pkg::t_cfg_idx'(2'd3), 5);
        set_frame(5, 2, 20);
        run_frame(5, 2);
    endtask

    // Config write mid-frame drops pending results
    task automatic test_restart();
        set_frame(6, 6, 5);
        repeat (10) send_item(rand_pixel());
        repeat (800) @(negedge i_clk);
        write_reg(rmf_pkg::CFG_WINDOW_SIZE, 3);
        run_frame(6, 6);
    endtask

    // Receiver stalls long while sender keeps offering
    task automatic test_backpressure();
        set_frame(8, 4, 3);
        sink_hold = 1;
        src_no_idle = 1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                sink_hold = 0;
            end
            run_frame(8, 4);
        join
        src_no_idle = 0;
    endtask

    // Random frames, mostly small; no idling in one stretch
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 300) begin
            int unsigned w, h, s;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            s = $urandom_range(0, 31);
            set_frame(w, h, s);
            if (sent > 100 && sent < 220) begin
                src_no_idle = 1;
                sink_no_idle = 1;
            end else begin
                src_no_idle = 0;
                sink_no_idle = 0;
            end
            if ($urandom_range(9) == 0) send_flush();
            run_frame(w, h);
            sent += w * h;
        end
        src_no_idle = 0;
        sink_no_idle = 0;
    endtask

    // Sink ready: random idling, long hold on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= !sink_hold && (sink_no_idle || $urandom_range(99) >= 13);
        end
    end

    // Result checker
    initial begin
        rmf_pkg::t_out_item got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (median_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    errors++;
                end else begin
                    want = median_q.pop_front();
                    if (got.red_out !== want.red_out) begin
                        $error("red_out exp %0d got %0d", want.red_out, got.red_out);
                        errors++;
                    end
                    if (got.green_out !== want.green_out) begin
                        $error("green_out exp %0d got %0d", want.green_out, got.green_out);
                        errors++;
                    end
                    if (got.blue_out !== want.blue_out) begin
                        $error("blue_out exp %0d got %0d", want.blue_out, got.blue_out);
                        errors++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end exp %0d got %0d", want.frame_end, got.frame_end);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    initial begin
        forever begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG) begin
                $display("rgb_median_filter_tb failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.payload = '0;
        img_w_reg = 1;
        img_h_reg = 1;
        win_reg = 3;
        frame_restart();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_extremes();
        test_restart();
        test_backpressure();
        drain_wait();
        test_random();
        drain_wait();
        if (errors == 0 && median_q.size() == 0)
            $display("rgb_median_filter_tb passed");
        else
            $display("rgb_median_filter_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/rmf_pkg.sv
sv/rmf_stream_if.sv
sv/rmf_ram.sv
sv/rmf_hist.sv
sv/rgb_median_filter.sv
test/rgb_median_filter_tb.sv
